>>> design/header_keyed_xor_word_descrambler_macros.svh
// Assertion macros shared by the descrambler modules.
// Depends on nothing; the asserting files include it by name.
`ifndef HEADER_KEYED_XOR_WORD_DESCRAMBLER_MACROS_SVH
`define HEADER_KEYED_XOR_WORD_DESCRAMBLER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HKXD_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HKXD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/hkxd_pkg.sv
// Types and constants shared by the header-keyed XOR word descrambler.
// No dependencies; every design module imports this package.
package hkxd_pkg;

    localparam logic [31:0] HDR_LEN      = 32'd20;
    localparam logic [31:0] MAGIC_LEN    = 32'd8;
    localparam logic [31:0] LAST_HDR_POS = 32'd19;
    localparam logic [31:0] WORD_BYTES   = 32'd4;

    // Magic bytes, first byte in bits 7:0.
    localparam logic [63:0] MAGIC_BYTES  = 64'h6564_6172_746D_6567;

    // Input stall after a length write, covering the word-advance lookahead.
    localparam logic [1:0]  CFG_HOLD     = 2'd3;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_SHORT     = 2'd1,
        ST_BAD_MAGIC = 2'd2
    } t_status;

    typedef struct packed {
        logic [31:0] fl;
        logic [31:0] plen;
        logic        short_file;
        logic        busy;
    } t_cfg;

    typedef struct packed {
        logic [31:0] key_a;
        logic [31:0] interval;
        logic [31:0] skip;
    } t_hdr;

    typedef struct packed {
        logic [31:0] next_pos;
        logic        stop;
        logic        done_after;
    } t_adv;

    typedef struct packed {
        logic        has_res;
        logic [7:0]  data;
        t_status     status;
        logic        last;
        logic        xor_en;
        logic [1:0]  lane;
        logic [31:0] widx;
    } t_token;

endpackage

>>> design/hkxd_adv.sv
// Lookahead for the next word position: a short pipeline that keeps the
// next position ready from the current one. Depends on hkxd_pkg.
module hkxd_adv import hkxd_pkg::*; (
    input  logic        i_clk,
    input  logic [31:0] i_next_word_pos,
    input  logic [31:0] i_plen,
    input  t_hdr        i_hdr,
    output t_adv        o_adv
);

    logic [32:0] r_v;
    logic        r_stop;
    logic [31:0] r_clamp;
    logic        r_clamp_fail;
    logic        r_jump;
    logic [33:0] r_v2;
    logic [31:0] r_next;
    logic        r_done_after;

    logic        w_over;
    logic        w_fit_fail;

    // A jump that lands too close to the end is clamped to plen - interval.
    always_comb begin
        w_over     = ({1'b0, r_v2} + {3'b000, i_hdr.interval}) > {3'b000, i_plen};
        w_fit_fail = (r_v2 + 34'd4) > {2'b00, i_plen};
    end

    always_ff @(posedge i_clk) begin
        r_v          <= {1'b0, i_next_word_pos} + 33'd4;
        r_stop       <= ({2'b00, i_next_word_pos} + 34'd8) > {2'b00, i_plen};
        r_clamp      <= i_plen - i_hdr.interval;
        r_clamp_fail <= i_hdr.interval < WORD_BYTES;
        r_jump       <= ({1'b0, i_hdr.interval} <= r_v) &&
                        (({2'b00, i_hdr.interval} + {1'b0, r_v}) < {2'b00, i_plen});
        r_v2         <= {1'b0, r_v} + {2'b00, i_hdr.skip};
        r_next       <= r_jump ? (w_over ? r_clamp : r_v2[31:0]) : r_v[31:0];
        r_done_after <= r_jump && (w_over ? r_clamp_fail : w_fit_fail);
    end

    assign o_adv.next_pos   = r_next;
    assign o_adv.stop       = r_stop;
    assign o_adv.done_after = r_done_after;

endmodule

>>> design/hkxd_ctrl.sv
// Byte-position control: header capture, key parameters, word tracking and
// the first pipeline stage. Depends on hkxd_pkg and the macros header.
`include "header_keyed_xor_word_descrambler_macros.svh"

module hkxd_ctrl import hkxd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic [7:0]  i_data_byte,
    output logic        o_stall,
    input  t_cfg        i_cfg,
    input  t_adv        i_adv,
    input  logic        i_s2_free,
    output logic        o_s1_valid,
    output t_token      o_s1,
    output t_hdr        o_hdr,
    output logic [31:0] o_next_word_pos
);

    logic [31:0] r_byte_count;
    logic        r_magic_bad;
    logic [31:0] r_hdr_word [3];
    logic [31:0] r_interval;
    logic [31:0] r_skip;
    logic [31:0] r_key_a;
    logic [31:0] r_nwp;
    logic        r_decode_done;
    logic [31:0] r_word_idx;
    logic        r_s1_valid;
    t_token      r_s1;

    logic        w_s1_free;
    logic        w_acc;
    logic [31:0] w_pos;
    logic [32:0] w_pos_inc;
    logic        w_final;
    logic        w_first;
    logic        w_mb_eff;
    logic        w_in_hdr;
    logic        w_mismatch;
    logic [4:0]  w_hoff;
    logic [1:0]  w_hw_idx;
    logic [1:0]  w_hw_lane;
    logic [31:0] w_hw2_full;
    logic [31:0] w_sum;
    logic [31:0] w_dif;
    logic [31:0] w_p;
    logic [32:0] w_wdiff;
    logic        w_hit;
    logic        w_word_end;
    logic        w_advance;
    t_token      w_tok;

    assign w_s1_free = !r_s1_valid || i_s2_free;
    // The input also stalls while reset is asserted.
    assign o_stall   = !w_s1_free || i_cfg.busy || !i_rst_n;
    assign w_acc     = i_valid && !o_stall;

    always_comb begin
        w_pos      = r_byte_count;
        w_pos_inc  = {1'b0, w_pos} + 33'd1;
        w_final    = w_pos_inc >= {1'b0, i_cfg.fl};
        w_first    = (w_pos == 32'd0);
        w_mb_eff   = w_first ? 1'b0 : r_magic_bad;
        w_in_hdr   = w_pos < HDR_LEN;
        w_mismatch = (w_pos < MAGIC_LEN) &&
                     (i_data_byte != MAGIC_BYTES[{w_pos[2:0], 3'b000} +: 8]);
        w_hoff     = w_pos[4:0] - 5'd8;
        w_hw_idx   = w_hoff[3:2];
        w_hw_lane  = w_hoff[1:0];
        // The last header byte completes word c in the same cycle.
        w_hw2_full = {i_data_byte, r_hdr_word[2][23:0]};
        w_sum      = r_hdr_word[1] + w_hw2_full;
        w_dif      = r_hdr_word[1] - w_hw2_full;
        w_p        = w_pos - HDR_LEN;
        w_wdiff    = {1'b0, w_p} - {1'b0, r_nwp};
        w_hit      = !r_decode_done && !w_wdiff[32] && (w_wdiff[31:2] == 30'd0);
        w_word_end = w_hit && (w_wdiff[1:0] == 2'd3);
        w_advance  = !i_cfg.short_file && !w_in_hdr && !r_magic_bad && w_word_end;
    end

    always_comb begin
        w_tok        = '0;
        w_tok.status = ST_OK;
        priority if (i_cfg.short_file) begin
            if (w_final) begin
                w_tok.has_res = 1'b1;
                w_tok.status  = ST_SHORT;
                w_tok.last    = 1'b1;
            end
        end else if (w_in_hdr) begin
            if (w_final && (w_mb_eff || w_mismatch)) begin
                w_tok.has_res = 1'b1;
                w_tok.status  = ST_BAD_MAGIC;
                w_tok.last    = 1'b1;
            end
        end else if (r_magic_bad) begin
            if (w_final) begin
                w_tok.has_res = 1'b1;
                w_tok.status  = ST_BAD_MAGIC;
                w_tok.last    = 1'b1;
            end
        end else begin
            w_tok.has_res = 1'b1;
            w_tok.data    = i_data_byte;
            w_tok.last    = w_final;
            w_tok.xor_en  = w_hit;
            w_tok.lane    = w_wdiff[1:0];
            w_tok.widx    = r_word_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count  <= '0;
            r_magic_bad   <= 1'b0;
            r_hdr_word    <= '{default: '0};
            r_interval    <= '0;
            r_skip        <= '0;
            r_key_a       <= '0;
            r_nwp         <= '0;
            r_decode_done <= 1'b0;
            r_word_idx    <= '0;
        end else if (w_acc) begin
            r_byte_count <= w_final ? 32'd0 : w_pos_inc[31:0];
            if (w_first) begin
                r_magic_bad   <= 1'b0;
                r_decode_done <= 1'b0;
                r_nwp         <= '0;
            end
            if (!i_cfg.short_file && w_in_hdr) begin
                r_magic_bad <= w_mb_eff || w_mismatch;
                if (w_pos >= MAGIC_LEN) begin
                    r_hdr_word[w_hw_idx][{w_hw_lane, 3'b000} +: 8] <= i_data_byte;
                end
                if (w_pos == LAST_HDR_POS) begin
                    r_interval    <= {1'b0, w_sum[31:1]};
                    r_skip        <= {1'b0, w_dif[31:1]};
                    r_key_a       <= r_hdr_word[0];
                    r_word_idx    <= '0;
                    r_nwp         <= '0;
                    r_decode_done <= i_cfg.plen < WORD_BYTES;
                end
            end else if (w_advance) begin
                // The key drops by one per word; the output stage subtracts this count.
                r_word_idx <= r_word_idx + 32'd1;
                if (i_adv.stop) begin
                    r_decode_done <= 1'b1;
                end else begin
                    r_nwp         <= i_adv.next_pos;
                    r_decode_done <= i_adv.done_after;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_s1_free) begin
            r_s1_valid <= w_acc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_free) begin
            r_s1 <= w_tok;
        end
    end

    assign o_s1_valid      = r_s1_valid;
    assign o_s1            = r_s1;
    assign o_hdr.key_a     = r_key_a;
    assign o_hdr.interval  = r_interval;
    assign o_hdr.skip      = r_skip;
    assign o_next_word_pos = r_nwp;

    `HKXD_ASSERT_NEXT(a_final_wraps, i_clk, i_rst_n, w_acc && w_final,
        r_byte_count == 32'd0, "byte count did not restart after the final byte")
    `HKXD_ASSERT_NEXT(a_hdr_restart, i_clk, i_rst_n,
        w_acc && !i_cfg.short_file && (w_pos == LAST_HDR_POS),
        (r_word_idx == 32'd0) && (r_nwp == 32'd0), "word tracking not restarted at header end")
    `HKXD_ASSERT_NEXT(a_pos_advances, i_clk, i_rst_n, w_acc && w_advance && !i_adv.stop,
        r_nwp > $past(r_nwp), "next word position did not move forward")

endmodule

>>> design/hkxd_out.sv
// Second pipeline stage, key derivation and the output register.
// Depends on hkxd_pkg and the macros header.
`include "header_keyed_xor_word_descrambler_macros.svh"

module hkxd_out import hkxd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s1_valid,
    input  t_token      i_s1,
    input  t_hdr        i_hdr,
    input  logic        i_stall,
    output logic        o_s2_free,
    output logic        o_valid,
    output logic [7:0]  o_out_byte,
    output t_status     o_status,
    output logic        o_last
);

    logic [31:0] r_prod;
    logic [31:0] r_key_base;
    logic        r_s2_valid;
    t_token      r_s2;
    logic        r_o_valid;
    logic [7:0]  r_o_byte;
    t_status     r_o_status;
    logic        r_o_last;

    logic        w_out_ready;
    logic        w_s2_move;
    logic        w_s2_free;
    logic [31:0] w_prod;
    logic [31:0] w_key;
    logic [7:0]  w_mask;

    // Key parameters settle through r_prod and then r_key_base after the header
    // ends, before the first payload byte reaches this stage.
    assign w_prod = i_hdr.interval * i_hdr.skip;

    always_ff @(posedge i_clk) begin
        r_prod     <= w_prod;
        r_key_base <= i_hdr.key_a - r_prod;
    end

    always_comb begin
        w_out_ready = !r_o_valid || !i_stall;
        w_s2_move   = r_s2_valid && (!r_s2.has_res || w_out_ready);
        w_s2_free   = !r_s2_valid || w_s2_move;
        w_key       = r_key_base - r_s2.widx;
        w_mask      = r_s2.xor_en ? w_key[{r_s2.lane, 3'b000} +: 8] : 8'h00;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            if (w_s2_free) begin
                r_s2_valid <= i_s1_valid;
            end
            if (w_out_ready) begin
                r_o_valid <= w_s2_move && r_s2.has_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s2_free) begin
            r_s2 <= i_s1;
        end
        if (w_out_ready && w_s2_move && r_s2.has_res) begin
            r_o_byte   <= r_s2.data ^ w_mask;
            r_o_status <= r_s2.status;
            r_o_last   <= r_s2.last;
        end
    end

    assign o_s2_free  = w_s2_free;
    assign o_valid    = r_o_valid;
    assign o_out_byte = r_o_byte;
    assign o_status   = r_o_status;
    assign o_last     = r_o_last;

    `HKXD_ASSERT_NOW(a_err_is_last, i_clk, i_rst_n, r_o_valid && (r_o_status != ST_OK),
        r_o_last && (r_o_byte == 8'h00), "error result not final or not zero")
    `HKXD_ASSERT_NOW(a_xor_ok_only, i_clk, i_rst_n, r_s2_valid && r_s2.xor_en,
        r_s2.has_res && (r_s2.status == ST_OK), "descrambled byte on a non-ok transaction")
    `HKXD_ASSERT_NOW(a_valid_source, i_clk, i_rst_n, $rose(r_o_valid),
        $past(r_s2_valid && r_s2.has_res), "output valid without a result token")

endmodule

>>> design/header_keyed_xor_word_descrambler.sv
// Header-keyed XOR word descrambler, one file byte per transaction.
// Input channel: i_valid / o_stall with i_data_byte. Output channel: o_valid /
// i_stall with o_out_byte, o_status and o_last.
// Configuration: i_cfg_wr_en / i_cfg_wr_data set the total file length
// (header included); write it while the block is idle.
// Each byte is held in the first and then the second pipeline stage before its
// result loads the output register.
// While the input does not stall, one byte is accepted every cycle; the
// per-byte work is a compare and an XOR, and the next word position comes from
// a three-stage lookahead unit. After a length write the input stalls while
// that lookahead reloads.
// Header bytes and bytes of a file with a bad magic give no transaction; in a
// bad or short file the final byte still gives one, carrying the error status.
// When the receiver stalls, the output register holds; the two pipeline
// stages behind it still fill before the input stalls.
// Reset (synchronous, active low) clears the length to zero and starts a new
// file with the next byte.
// Depends on hkxd_pkg, hkxd_ctrl, hkxd_adv and hkxd_out.
module header_keyed_xor_word_descrambler import hkxd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic [1:0]  o_status,
    output logic        o_last
);

    logic [31:0] r_fl;
    logic [31:0] r_plen;
    logic        r_short;
    logic [1:0]  r_hold;

    t_cfg        w_cfg;
    t_adv        w_adv;
    t_hdr        w_hdr;
    t_token      w_s1;
    logic        w_s1_valid;
    logic        w_s2_free;
    logic [31:0] w_nwp;
    t_status     w_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fl    <= '0;
            r_plen  <= 32'd0 - HDR_LEN;
            r_short <= 1'b1;
            r_hold  <= '0;
        end else if (i_cfg_wr_en) begin
            r_fl    <= i_cfg_wr_data;
            r_plen  <= i_cfg_wr_data - HDR_LEN;
            r_short <= i_cfg_wr_data < HDR_LEN;
            r_hold  <= CFG_HOLD;
        end else if (r_hold != 2'd0) begin
            r_hold <= r_hold - 2'd1;
        end
    end

    assign w_cfg.fl         = r_fl;
    assign w_cfg.plen       = r_plen;
    assign w_cfg.short_file = r_short;
    assign w_cfg.busy       = (r_hold != 2'd0);

    hkxd_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .i_data_byte     (i_data_byte),
        .o_stall         (o_stall),
        .i_cfg           (w_cfg),
        .i_adv           (w_adv),
        .i_s2_free       (w_s2_free),
        .o_s1_valid      (w_s1_valid),
        .o_s1            (w_s1),
        .o_hdr           (w_hdr),
        .o_next_word_pos (w_nwp)
    );

    hkxd_adv u_adv (
        .i_clk           (i_clk),
        .i_next_word_pos (w_nwp),
        .i_plen          (r_plen),
        .i_hdr           (w_hdr),
        .o_adv           (w_adv)
    );

    hkxd_out u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s1_valid (w_s1_valid),
        .i_s1       (w_s1),
        .i_hdr      (w_hdr),
        .i_stall    (i_stall),
        .o_s2_free  (w_s2_free),
        .o_valid    (o_valid),
        .o_out_byte (o_out_byte),
        .o_status   (w_status),
        .o_last     (o_last)
    );

    assign o_status = w_status;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for header_keyed_xor_word_descrambler.
// Drives files one byte per transaction and predicts every decoded byte.
// Depends on hkxd_pkg and the descrambler RTL only.
module tb_top;
    import hkxd_pkg::*;

    localparam int NO_BAD = 8;    // build_header: leave the magic intact

    typedef struct packed {
        logic [7:0] data;
        t_status    status;
        logic       last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_wr_en   = 1'b0;
    logic [31:0] i_cfg_wr_data = 32'd0;
    logic        i_valid       = 1'b0;
    logic [7:0]  i_data_byte   = 8'd0;
    logic        i_stall       = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [7:0]  o_out_byte;
    logic [1:0]  o_status;
    logic        o_last;

    // Predicted descrambler state.
    logic [31:0] m_len   = '0;
    logic [31:0] m_count = '0;
    logic        m_bad   = 1'b0;
    logic [31:0] m_word [3] = '{32'd0, 32'd0, 32'd0};
    logic [31:0] m_interval = '0;
    logic [31:0] m_skip  = '0;
    logic [31:0] m_key   = '0;
    logic [31:0] m_next  = '0;
    logic        m_done  = 1'b0;

    t_result     decoded_fifo [$];
    t_result     next_res, head_res;
    logic [7:0]  hdr_img [20];
    bit          no_idle  = 1'b0;
    int unsigned n_sent   = 0;
    int unsigned n_errors = 0;

    header_keyed_xor_word_descrambler u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_byte    (o_out_byte),
        .o_status      (o_status),
        .o_last        (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #1_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    // Marks decoding as finished when no whole word fits at the next position.
    function automatic void stop_if_no_room(input logic [31:0] plen);
        if ({32'd0, m_next} + 64'd4 > {32'd0, plen})
            m_done = 1'b1;
    endfunction

    // Steps the key down and moves to the next word position after the last byte of a word.
    function automatic void advance_word_pos(input logic [31:0] plen);
        logic [63:0] v, p64, i64;
        v   = {32'd0, m_next} + 64'd4;
        p64 = {32'd0, plen};
        i64 = {32'd0, m_interval};
        m_key = m_key - 32'd1;
        if (v > p64 || p64 - v < 64'd4) begin
            m_done = 1'b1;
        end else begin
            // Past the interval each word is followed by a jump; an overshoot is
            // pulled back so the last interval bytes still decode contiguously.
            if (i64 <= v && i64 < p64 - v) begin
                v = v + {32'd0, m_skip};
                if (v > p64 || i64 > p64 - v)
                    v = p64 - i64;
            end
            m_next = v[31:0];
            stop_if_no_room(plen);
        end
    endfunction

    function automatic bit descramble_byte(input logic [7:0] b, output t_result r);
        logic [31:0] pos, plen, p, k;
        bit          is_last, has;
        pos     = m_count;
        plen    = m_len - HDR_LEN;
        is_last = ({32'd0, pos} + 64'd1) >= {32'd0, m_len};
        has     = 1'b0;
        r       = '{data: 8'd0, status: ST_OK, last: 1'b0};
        if (pos == 32'd0) begin
            m_bad  = 1'b0;
            m_done = 1'b0;
            m_next = 32'd0;
        end
        if (m_len < HDR_LEN) begin
            if (is_last) begin
                r   = '{data: 8'd0, status: ST_SHORT, last: 1'b1};
                has = 1'b1;
            end
        end else if (pos < HDR_LEN) begin
            if (pos < MAGIC_LEN) begin
                if (b != MAGIC_BYTES[8*pos[2:0] +: 8])
                    m_bad = 1'b1;
            end else begin
                k = (pos - MAGIC_LEN) >> 2;
                m_word[k[1:0]][8*pos[1:0] +: 8] = b;
            end
            if (pos == LAST_HDR_POS) begin
                m_interval = (m_word[1] + m_word[2]) >> 1;
                m_skip     = (m_word[1] - m_word[2]) >> 1;
                m_key      = m_word[0] - m_interval * m_skip;
                m_next     = 32'd0;
                m_done     = 1'b0;
                stop_if_no_room(plen);
            end
            if (is_last && m_bad) begin
                r   = '{data: 8'd0, status: ST_BAD_MAGIC, last: 1'b1};
                has = 1'b1;
            end
        end else if (m_bad) begin
            if (is_last) begin
                r   = '{data: 8'd0, status: ST_BAD_MAGIC, last: 1'b1};
                has = 1'b1;
            end
        end else begin
            p      = pos - HDR_LEN;
            r.data = b;
            if (!m_done && p >= m_next && p - m_next < WORD_BYTES) begin
                k      = p - m_next;
                r.data = b ^ m_key[8*k[1:0] +: 8];
                if (k == WORD_BYTES - 1)
                    advance_word_pos(plen);
            end
            r.last = is_last;
            has    = 1'b1;
        end
        m_count = is_last ? 32'd0 : pos + 32'd1;
        return has;
    endfunction

    always @(posedge i_clk) begin
        i_stall <= no_idle ? 1'b0 : ($urandom_range(0, 99) < 13);
    end

    // Predicts each accepted byte, then checks each delivered result in order.
    always @(posedge i_clk) begin
        if (i_rst_n && i_valid && !o_stall) begin
            if (descramble_byte(i_data_byte, next_res))
                decoded_fifo.push_back(next_res);
        end
        if (i_rst_n && o_valid && !i_stall) begin
            if (decoded_fifo.size() == 0) begin
                $display("%0t: unexpected result byte %02h status %0d last %0b",
                         $time, o_out_byte, o_status, o_last);
                n_errors++;
            end else begin
                head_res = decoded_fifo.pop_front();
                if (o_out_byte !== head_res.data) begin
                    $display("%0t: out_byte expected %02h, got %02h",
                             $time, head_res.data, o_out_byte);
                    n_errors++;
                end
                if (o_status !== head_res.status) begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, head_res.status, o_status);
                    n_errors++;
                end
                if (o_last !== head_res.last) begin
                    $display("%0t: last expected %0b, got %0b",
                             $time, head_res.last, o_last);
                    n_errors++;
                end
            end
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while (!no_idle && $urandom_range(0, 99) < 13) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
    endtask

    // Waits until every predicted result has been delivered and the pipeline
    // has drained the bytes that give no result.
    task automatic wait_idle();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (decoded_fifo.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic set_length(input logic [31:0] len);
        wait_idle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= len;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        m_len = len;
    endtask

    function automatic logic [7:0] payload_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic build_header(input logic [31:0] ha, input logic [31:0] hb,
                                input logic [31:0] hc, input int bad_at);
        logic [7:0] flip;
        flip = 8'($urandom_range(1, 255));
        for (int i = 0; i < 8; i++)
            hdr_img[i] = MAGIC_BYTES[8*i +: 8] ^ ((i == bad_at) ? flip : 8'h00);
        for (int j = 0; j < 4; j++) begin
            hdr_img[8 + j]  = ha[8*j +: 8];
            hdr_img[12 + j] = hb[8*j +: 8];
            hdr_img[16 + j] = hc[8*j +: 8];
        end
    endtask

    task automatic send_span(input int unsigned from, input int unsigned count);
        for (int unsigned i = from; i < from + count; i++) begin
            // Now and then hold off until the output side has caught up.
            if (!no_idle && $urandom_range(0, 299) == 0)
                wait_idle();
            send_byte((i < 20) ? hdr_img[i] : payload_byte());
        end
    endtask

    task automatic send_file(input logic [31:0] len, input logic [31:0] ha,
                             input logic [31:0] hb, input logic [31:0] hc,
                             input int bad_at);
        build_header(ha, hb, hc, bad_at);
        set_length(len);
        send_span(0, (len == 0) ? 1 : len);
    endtask

    // Sends the rest of the current file under the length now in force.
    task automatic finish_file();
        logic [31:0] rest;
        rest = ({32'd0, m_count} + 64'd1 >= {32'd0, m_len}) ? 32'd1 : m_len - m_count;
        send_span(m_count, rest);
    endtask

    // Header words chosen so that interval = iv and skip = sk.
    task automatic keyed_file(input logic [31:0] plen, input logic [31:0] iv,
                              input logic [31:0] sk, input logic [31:0] ha);
        send_file(HDR_LEN + plen, ha, iv + sk, iv - sk, NO_BAD);
    endtask

    task automatic random_file();
        int unsigned kind, plen;
        logic [31:0] iv, sk, hb, hc;
        kind = $urandom_range(0, 99);
        plen = ($urandom_range(0, 14) == 0) ? $urandom_range(100, 300)
                                            : $urandom_range(0, 48);
        case ($urandom_range(0, 5))
            0:       iv = $urandom;
            1, 2:    iv = $urandom_range(0, 12);
            default: iv = $urandom_range(0, plen + 4);
        endcase
        case ($urandom_range(0, 5))
            0:       sk = $urandom;
            1:       sk = plen + $urandom_range(0, 8);
            default: sk = $urandom_range(0, 10);
        endcase
        hb = iv + sk;
        hc = iv - sk;
        if ($urandom_range(0, 9) == 0) begin
            hb = $urandom;
            hc = $urandom;
        end
        if (kind < 6)
            send_file($urandom_range(0, 19), $urandom, hb, hc, NO_BAD);
        else if (kind < 12)
            send_file(HDR_LEN + $urandom_range(0, 20), $urandom, hb, hc,
                      $urandom_range(0, 7));
        else
            send_file(HDR_LEN + plen, $urandom, hb, hc, NO_BAD);
    endtask

    task automatic test_short_files();
        set_length(32'd0);
        send_byte(8'h00);
        send_byte(8'hFF);
        set_length(32'd1);
        send_byte(8'hFF);
        send_byte(8'h00);
        send_file(32'd5, 32'd0, 32'd0, 32'd0, NO_BAD);
        send_file(32'd19, 32'hFFFF_FFFF, 32'd0, 32'd0, NO_BAD);
    endtask

    task automatic test_bad_magic();
        send_file(32'd20, 32'd1, 32'd2, 32'd3, 7);
        send_file(32'd26, 32'd1, 32'd2, 32'd3, 0);
    endtask

    task automatic test_small_payloads();
        keyed_file(32'd0, 32'd0, 32'd0, 32'h1234_5678);
        keyed_file(32'd1, 32'd0, 32'd0, 32'h1234_5678);
        keyed_file(32'd3, 32'd0, 32'd0, 32'h1234_5678);
        keyed_file(32'd4, 32'd0, 32'd0, 32'hA5A5_5A5A);
        keyed_file(32'd7, 32'd0, 32'd0, 32'hFFFF_FFFF);
    endtask

    task automatic test_word_spacing();
        // Contiguous words, key running down through zero, a tail that does not fit.
        keyed_file(32'd14, 32'd0, 32'd0, 32'd0);
        keyed_file(32'd40, 32'd8, 32'd3, 32'hDEAD_BEEF);
        keyed_file(32'd30, 32'd6, 32'd50, 32'h0BAD_F00D);
        keyed_file(32'd24, 32'd4, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
        keyed_file(32'd20, 32'd100, 32'd2, 32'h0000_0001);
    endtask

    task automatic test_length_changes();
        logic [31:0] len;
        build_header(32'hC0DE_0001, 32'd7, 32'd1, NO_BAD);
        set_length(32'hFFFF_FFFF);
        send_span(0, 30);
        set_length(32'd41);
        finish_file();
        set_length(32'd60);
        send_span(0, 34);
        set_length(32'd25);
        finish_file();
        set_length(32'd12);
        send_span(0, 6);
        set_length(32'd44);
        finish_file();
        set_length(32'd50);
        send_span(0, 10);
        set_length(32'd8);
        finish_file();
        repeat (3) begin
            build_header($urandom, $urandom_range(0, 30), $urandom_range(0, 10),
                         ($urandom_range(0, 4) == 0) ? $urandom_range(0, 7) : NO_BAD);
            len = HDR_LEN + $urandom_range(0, 60);
            set_length(len);
            send_span(0, $urandom_range(1, len - 1));
            set_length($urandom_range(0, 90));
            finish_file();
        end
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        keyed_file(32'd300, 32'd16, 32'd5, 32'h5555_AAAA);
        repeat (2) random_file();
        no_idle = 1'b0;
    endtask

    task automatic test_random_files();
        int unsigned start;
        start = n_sent;
        while (n_sent < start + 300)
            random_file();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_files();
        test_bad_magic();
        test_small_payloads();
        test_word_spacing();
        test_length_changes();
        test_back_to_back();
        test_random_files();
        wait_idle();
        if (n_errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

>>> sim.f
+incdir+design
design/hkxd_pkg.sv
design/hkxd_adv.sv
design/hkxd_ctrl.sv
design/hkxd_out.sv
design/header_keyed_xor_word_descrambler.sv
tb/tb_top.sv
